@@ hw/rtl/pvd_pkg.sv @@
// Shared types and constants of the prefix varint decoder.
package pvd_pkg;

    // Stream payload of one encoded byte
    typedef struct packed {
        logic [7:0] data_byte;
    } byte_item_t;

    // Stream payload of one decoded value
    typedef struct packed {
        logic [63:0] decoded_value;
        logic [3:0]  encoded_length;
        logic        format_error;
    } value_item_t;

    // Decoded value plus its valid strobe, decoder to output buffer
    typedef struct packed {
        logic        valid;
        value_item_t item;
    } value_push_t;

    // Data bits that may not be set once shifted by the header width
    localparam logic [63:0] OVERFLOW_MASK = 64'hfe00_0000_0000_0000;

    // Lengths of the results that come straight from a header byte
    localparam logic [3:0] LEN_SINGLE     = 4'd1;
    localparam logic [3:0] LEN_BAD_HEADER = 4'd2;

    // Data bytes after a two-byte header, on top of its length marker
    localparam logic [3:0] LONG_DATA_BASE = 4'd7;

    // Length added to the data byte count by a one-byte header
    localparam logic [3:0] HEADER_LEN = 4'd1;

endpackage

@@ hw/rtl/pvd_stream_if.sv @@
// Valid/ready stream channel with a typed payload.
interface pvd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/pvd_byte_decoder.sv @@
// Decode state and per-byte decode logic of the prefix varint decoder.
module pvd_byte_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    output pvd_pkg::value_push_t result
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_HEADER2 = 2'd1,
        PH_DATA1   = 2'd2,
        PH_DATA2   = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  left_reg, left_next;
    logic [6:0]  payload_reg, payload_next;
    logic [2:0]  shift_reg, shift_next;
    logic [63:0] data_reg, data_next;
    logic [2:0]  pos_reg, pos_next;

    logic [2:0]  first_k;
    logic [3:0]  left_dec;
    logic [63:0] merged;
    logic [63:0] ovf_mask;
    logic [2:0]  data_k;
    logic [3:0]  data_len;

    // Position of the lowest set bit of a nonzero even header byte
    always_comb
    begin
        if (data_byte[1])
            first_k = 3'd1;
        else if (data_byte[2])
            first_k = 3'd2;
        else if (data_byte[3])
            first_k = 3'd3;
        else if (data_byte[4])
            first_k = 3'd4;
        else if (data_byte[5])
            first_k = 3'd5;
        else if (data_byte[6])
            first_k = 3'd6;
        else
            first_k = 3'd7;
    end

    // Data byte merge, overflow check and length
    always_comb
    begin
        left_dec = (left_reg == 4'd0) ? 4'd0 : left_reg - 4'd1;
        merged   = data_reg | ({56'd0, data_byte} << {pos_reg, 3'b000});
        data_k   = 3'd7 - shift_reg;
        ovf_mask = pvd_pkg::OVERFLOW_MASK << data_k;
        data_len = {1'b0, pos_reg} + 4'd1 + pvd_pkg::HEADER_LEN
                 + ((phase_reg == PH_DATA2) ? 4'd1 : 4'd0);
    end

    // Next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        payload_next = payload_reg;
        shift_next   = shift_reg;
        data_next    = data_reg;
        pos_next     = pos_reg;
        result       = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (data_byte[0])
                    begin
                        result.valid                = 1'b1;
                        result.item.decoded_value   = {57'd0, data_byte[7:1]};
                        result.item.encoded_length  = pvd_pkg::LEN_SINGLE;
                    end
                    else if (data_byte == 8'd0)
                    begin
                        phase_next = PH_HEADER2;
                    end
                    else
                    begin
                        payload_next = 7'(data_byte >> ({1'b0, first_k} + 4'd1));
                        shift_next   = 3'd7 - first_k;
                        left_next    = {1'b0, first_k};
                        data_next    = '0;
                        pos_next     = '0;
                        phase_next   = PH_DATA1;
                    end
                end
                PH_HEADER2:
                begin
                    if (data_byte[1:0] == 2'b00)
                    begin
                        result.valid               = 1'b1;
                        result.item.encoded_length = pvd_pkg::LEN_BAD_HEADER;
                        result.item.format_error   = 1'b1;
                        phase_next                 = PH_HEADER;
                        left_next                  = '0;
                        payload_next               = '0;
                        shift_next                 = '0;
                        data_next                  = '0;
                        pos_next                   = '0;
                    end
                    else
                    begin
                        // bit 0 set: k = 0, otherwise k = 1
                        payload_next = data_byte[0] ? data_byte[7:1] : {1'b0, data_byte[7:2]};
                        shift_next   = data_byte[0] ? 3'd7 : 3'd6;
                        left_next    = pvd_pkg::LONG_DATA_BASE + (data_byte[0] ? 4'd0 : 4'd1);
                        data_next    = '0;
                        pos_next     = '0;
                        phase_next   = PH_DATA2;
                    end
                end
                default:
                begin
                    // data bytes, little-endian above the header bits
                    if (left_dec != 4'd0)
                    begin
                        data_next = merged;
                        pos_next  = pos_reg + 3'd1;
                        left_next = left_dec;
                    end
                    else
                    begin
                        result.valid               = 1'b1;
                        result.item.encoded_length = data_len;
                        if ((merged & ovf_mask) != 64'd0)
                            result.item.format_error = 1'b1;
                        else
                            result.item.decoded_value = (merged << shift_reg)
                                                      | {57'd0, payload_reg};
                        phase_next   = PH_HEADER;
                        left_next    = '0;
                        payload_next = '0;
                        shift_next   = '0;
                        data_next    = '0;
                        pos_next     = '0;
                    end
                end
            endcase
        end
    end

    // Decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            left_reg    <= '0;
            payload_reg <= '0;
            shift_reg   <= '0;
            data_reg    <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            payload_reg <= payload_next;
            shift_reg   <= shift_next;
            data_reg    <= data_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

@@ hw/rtl/pvd_out_buffer.sv @@
// Result register with a skid entry on the value stream.
module pvd_out_buffer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pvd_pkg::value_push_t push,
    output logic                 space,
    pvd_stream_if.source         value_stream
);

    logic                 out_valid_reg;
    pvd_pkg::value_item_t out_item_reg;
    logic                 skid_valid_reg;
    pvd_pkg::value_item_t skid_item_reg;
    logic                 pop;

    assign pop                  = out_valid_reg & value_stream.ready;
    assign space                = ~skid_valid_reg;
    assign value_stream.valid   = out_valid_reg;
    assign value_stream.payload = out_item_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg <= push.valid;
        end
        else if (push.valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payloads
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_item_reg <= skid_item_reg;
        end
        else if (!out_valid_reg || pop)
        begin
            if (push.valid)
                out_item_reg <= push.item;
        end
        else if (push.valid)
        begin
            skid_item_reg <= push.item;
        end
    end

endmodule

@@ hw/rtl/prefix_varint_decoder.sv @@
// Top level of the 64-bit prefix varint decoder.
//
// byte_stream carries one encoded byte per request; value_stream carries one
// decoded value per completed varint: the value, its length in bytes (1..10)
// and a format error flag (bad second header byte or a value past 64 bits,
// value reads zero then). Bytes that do not complete a varint give no request.
// Both channels use valid/ready; a request moves when both are high.
// A byte goes into an input register when it is taken; from there the bit scan
// and merge run against the decode state and load the result register that
// drives value_stream, or the skid entry while that register is held.
// One byte is taken every cycle while value_stream drains; the limit is the
// single decode stage that updates the state each cycle.
// When the receiver stalls, one more result parks in a skid entry and byte
// intake keeps going until that entry fills; then byte_stream.ready drops.
// Reset empties both registers and returns the decoder to await a header.
module prefix_varint_decoder (
    input  logic         clk,
    input  logic         rst_n,
    pvd_stream_if.sink   byte_stream,
    pvd_stream_if.source value_stream
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 space;
    logic                 fire;
    pvd_pkg::value_push_t push;

    assign fire              = in_valid_reg & space;
    assign byte_stream.ready = ~in_valid_reg | space;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_stream.ready)
            in_valid_reg <= byte_stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
            in_byte_reg <= byte_stream.payload.data_byte;
    end

    pvd_byte_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (fire),
        .data_byte (in_byte_reg),
        .result    (push)
    );

    pvd_out_buffer u_out_buffer (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .space        (space),
        .value_stream (value_stream)
    );

endmodule

@@ dv/tb_prefix_varint_decoder.sv @@
// Self-checking testbench for the 64-bit prefix varint decoder.
`timescale 1ns / 100ps

// Tracks the decoder state from accepted bytes and holds the values still due
class varint_tracker;

    typedef enum logic [1:0] {
        PH_HEADER     = 2'd0,
        PH_HEADER2    = 2'd1,
        PH_SHORT_DATA = 2'd2,
        PH_LONG_DATA  = 2'd3
    } decode_phase_t;

    decode_phase_t phase;
    logic [3:0]    left;
    logic [6:0]    hdr_bits;
    logic [2:0]    hdr_width;
    logic [63:0]   data;
    logic [3:0]    pos;

    pvd_pkg::value_item_t values_due[$];
    int unsigned          errors;

    function new();
        clear();
        errors = 0;
    endfunction

    // Back to awaiting a first header byte
    function void clear();
        phase     = PH_HEADER;
        left      = '0;
        hdr_bits  = '0;
        hdr_width = '0;
        data      = '0;
        pos       = '0;
    endfunction

    function int unsigned pending();
        return values_due.size();
    endfunction

    function void push_value(logic [63:0] value, logic [3:0] len, logic err);
        pvd_pkg::value_item_t item;
        item.decoded_value  = err ? 64'd0 : value;
        item.encoded_length = len;
        item.format_error   = err;
        values_due.push_back(item);
        clear();
    endfunction

    // Header decoded: keep its payload bits and count the data bytes to come
    function void start_field(logic [7:0] b, int unsigned k, logic [3:0] count,
                              decode_phase_t next_phase);
        hdr_bits  = 7'(b >> (k + 1));
        hdr_width = 3'(7 - k);
        left      = count;
        data      = '0;
        pos       = '0;
        phase     = next_phase;
    endfunction

    // One accepted byte request
    function void note_byte(logic [7:0] b);
        int unsigned k;
        logic [63:0] mask;
        logic [3:0]  len;
        case (phase)
            PH_HEADER:
            begin
                if (b[0])
                    push_value(64'(b[7:1]), pvd_pkg::LEN_SINGLE, 1'b0);
                else if (b == 8'h00)
                    phase = PH_HEADER2;
                else
                begin
                    k = 1;
                    while (!b[k])
                        k++;
                    start_field(b, k, 4'(k), PH_SHORT_DATA);
                end
            end
            PH_HEADER2:
            begin
                // length marker must sit in bit 0 or bit 1
                if (b[1:0] == 2'b00)
                    push_value(64'd0, pvd_pkg::LEN_BAD_HEADER, 1'b1);
                else
                begin
                    k = b[0] ? 0 : 1;
                    start_field(b, k, pvd_pkg::LONG_DATA_BASE + 4'(k), PH_LONG_DATA);
                end
            end
            default:
            begin
                data = data | (64'(b) << (8 * pos[2:0]));
                pos  = pos + 4'd1;
                if (left != 0)
                    left = left - 4'd1;
                if (left == 0)
                begin
                    k    = 7 - hdr_width;
                    len  = pos + pvd_pkg::HEADER_LEN + ((phase == PH_LONG_DATA) ? 4'd1 : 4'd0);
                    mask = pvd_pkg::OVERFLOW_MASK << k;
                    if ((data & mask) != 0)
                        push_value(64'd0, len, 1'b1);
                    else
                        push_value((data << hdr_width) | 64'(hdr_bits), len, 1'b0);
                end
            end
        endcase
    endfunction

    // One accepted value request against the oldest one due
    function void check_value(pvd_pkg::value_item_t got);
        pvd_pkg::value_item_t want;
        if (values_due.size() == 0)
        begin
            $display("%0t: unexpected value request: value %h length %0d error %0b",
                     $time, got.decoded_value, got.encoded_length, got.format_error);
            errors++;
            return;
        end
        want = values_due.pop_front();
        if (got.decoded_value !== want.decoded_value)
        begin
            $display("%0t: decoded_value expected %h actual %h",
                     $time, want.decoded_value, got.decoded_value);
            errors++;
        end
        if (got.encoded_length !== want.encoded_length)
        begin
            $display("%0t: encoded_length expected %0d actual %0d",
                     $time, want.encoded_length, got.encoded_length);
            errors++;
        end
        if (got.format_error !== want.format_error)
        begin
            $display("%0t: format_error expected %0b actual %0b",
                     $time, want.format_error, got.format_error);
            errors++;
        end
    endfunction

endclass

module tb_prefix_varint_decoder;

    localparam int unsigned BYTE_COUNT   = 1450;
    localparam int unsigned CALM_TAIL    = 150;
    localparam int unsigned HOLD_AT      = 400;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;

    pvd_stream_if #(.payload_t(pvd_pkg::byte_item_t))  byte_stream ();
    pvd_stream_if #(.payload_t(pvd_pkg::value_item_t)) value_stream ();

    prefix_varint_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_stream),
        .value_stream (value_stream)
    );

    varint_tracker tracker;
    int unsigned   sent_count;
    bit            calm;
    bit            hold_pending;
    bit            hold_asked;
    bit            drain_paused;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Watch both channels at the rising edge
    always @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
            tracker.note_byte(byte_stream.payload.data_byte);
        if (value_stream.valid && value_stream.ready)
            tracker.check_value(value_stream.payload);
    end

    // Offer one byte, at times with a random gap ahead of it, until it is taken
    task automatic send_byte(input logic [7:0] value);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            byte_stream.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        byte_stream.valid             <= 1'b1;
        byte_stream.payload.data_byte <= value;
        do
            @(posedge clk);
        while (!byte_stream.ready);
        @(negedge clk);
        sent_count++;
        if (sent_count >= BYTE_COUNT - CALM_TAIL)
            calm = 1'b1;
    endtask

    // One random encoding: mostly well formed, some bad headers and raw noise
    task automatic send_varint();
        logic [7:0]  seq[$];
        logic [7:0]  b;
        int unsigned form;
        int unsigned k;
        form = $urandom_range(0, 99);
        if (form < 8)
        begin
            repeat ($urandom_range(1, 6))
                seq.push_back(8'($urandom));
        end
        else if (form < 14)
        begin
            seq.push_back(8'h00);
            seq.push_back({6'($urandom), 2'b00});
        end
        else if (form < 34)
        begin
            // two header bytes, 7 or 8 data bytes
            k = $urandom_range(0, 1);
            b = 8'($urandom);
            b[0] = (k == 0);
            b[1] = (k == 1) ? 1'b1 : b[1];
            seq.push_back(8'h00);
            seq.push_back(b);
            repeat (7 + k)
                seq.push_back(8'($urandom));
            // with 8 data bytes, keep the top byte in range half of the time
            if (k == 1 && $urandom_range(0, 1) == 1)
                seq[seq.size() - 1] = seq[seq.size() - 1] & 8'h03;
        end
        else
        begin
            k = $urandom_range(0, 7);
            seq.push_back(8'(($urandom << (k + 1)) | (1 << k)));
            repeat (k)
                seq.push_back(8'($urandom));
        end
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Byte sender
    initial
    begin
        tracker                       = new();
        sent_count                    = 0;
        calm                          = 1'b0;
        hold_pending                  = 1'b0;
        hold_asked                    = 1'b0;
        drain_paused                  = 1'b0;
        rst_n                         = 1'b0;
        byte_stream.valid             = 1'b0;
        byte_stream.payload.data_byte = 8'h00;
        value_stream.ready            = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // single-byte extremes
        send_byte(8'h01);
        send_byte(8'hFF);
        // bad second header
        send_byte(8'h00);
        send_byte(8'h00);
        // largest value: two-byte header, top data byte just in range
        send_byte(8'h00);
        send_byte(8'hFE);
        repeat (7) send_byte(8'hFF);
        send_byte(8'h03);
        // overflow past 64 bits
        send_byte(8'h00);
        send_byte(8'hFE);
        repeat (8) send_byte(8'hFF);

        while (sent_count < BYTE_COUNT)
        begin
            send_varint();
            if (!hold_asked && sent_count >= HOLD_AT)
            begin
                hold_asked   = 1'b1;
                hold_pending = 1'b1;
            end
            // let the decoder drain completely once
            if (!drain_paused && sent_count >= BYTE_COUNT / 2)
            begin
                drain_paused = 1'b1;
                byte_stream.valid <= 1'b0;
                do
                    @(negedge clk);
                while (tracker.pending() != 0);
            end
        end
        byte_stream.valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Value receiver: random stall bursts, one long hold, steady at the end
    initial
    begin
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!calm && hold_pending)
            begin
                hold_pending = 1'b0;
                value_stream.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                value_stream.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            else
            begin
                value_stream.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(negedge clk);
            end
        end
    end

    // Run limit
    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/pvd_pkg.sv
hw/rtl/pvd_stream_if.sv
hw/rtl/pvd_byte_decoder.sv
hw/rtl/pvd_out_buffer.sv
hw/rtl/prefix_varint_decoder.sv
dv/tb_prefix_varint_decoder.sv
